@@ rtl/core/dcpa_pkg.sv @@
// ----------------------------------------------------------------------------
// dcpa_pkg
// Shared constants, types and helpers for the DSI command packet assembler.
// ----------------------------------------------------------------------------
`default_nettype none

package dcpa_pkg;

   // payload buffer per packet; two banks are kept in the byte RAM
   localparam int BUFFER_DEPTH = 32;
   localparam int IDX_W        = $clog2(BUFFER_DEPTH);
   localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
   localparam int RAM_DEPTH    = 2 * BUFFER_DEPTH;
   localparam int ADDR_W       = IDX_W + 1;

   // packet descriptor queue
   localparam int QCNT_W = 2;
   localparam logic [QCNT_W-1:0] QUEUE_EMPTY = 2'd0;
   localparam logic [QCNT_W-1:0] QUEUE_FULL  = 2'd2;

   // DSI data type codes
   localparam logic [5:0] DT_DCS_SHORT0 = 6'h05;
   localparam logic [5:0] DT_DCS_SHORT1 = 6'h15;
   localparam logic [5:0] DT_DCS_LONG   = 6'h39;
   localparam logic [5:0] DT_GEN_SHORT1 = 6'h13;
   localparam logic [5:0] DT_GEN_SHORT2 = 6'h23;
   localparam logic [5:0] DT_GEN_LONG   = 6'h29;

   typedef enum logic [2:0] {
      MODE_DCS   = 3'd0,
      MODE_GEN   = 3'd1,
      MODE_PARAM = 3'd2,
      MODE_END   = 3'd3,
      MODE_OTHER = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_DCS  = 2'd1,
      KIND_GEN  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [5:0]       data_type;
      logic [CNT_W-1:0] len;
      logic [7:0]       wait_ms;
      logic             ovf;
      logic             bank;
   } desc_type;

   typedef struct packed {
      logic     en;
      desc_type desc;
   } push_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } rd_type;

   function automatic logic [5:0] pick_type(kind_type kind, logic [CNT_W-1:0] n);
      logic [5:0] dt;
      if (kind == KIND_DCS) begin
         if (n <= CNT_W'(1))      dt = DT_DCS_SHORT0;
         else if (n == CNT_W'(2)) dt = DT_DCS_SHORT1;
         else                     dt = DT_DCS_LONG;
      end else begin
         if (n <= CNT_W'(1))      dt = DT_GEN_SHORT1;
         else if (n == CNT_W'(2)) dt = DT_GEN_SHORT2;
         else                     dt = DT_GEN_LONG;
      end
      return dt;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/dsi_command_packet_assembler_core.sv @@
// ----------------------------------------------------------------------------
// dsi_command_packet_assembler_core
// Turns tagged panel init table bytes into DSI write packets, one result
// transfer per payload byte, with the packet header on every transfer.
// ----------------------------------------------------------------------------
//
//  channel | ports prefix | direction | one transfer carries
//  --------+--------------+-----------+-------------------------------------
//  request | req_         | in        | entry byte, mode tag, wait value
//  result  | rsp_         | out       | type, length, wait, byte, last, ovf
//
// Cycles: a request transfer is taken every cycle while the front has room.
// Each packet drains at one result per unstalled cycle, reading the payload
// RAM; the read port and drain counter set that rate. Packets ping-pong over
// two RAM banks, so the front fills one while the back drains the other.
// Stalls: a request that flushes waits when two packets are already queued;
// a command waits until a free bank exists. Result stalls hold the output.
// Reset: control state only; no RAM clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module dsi_command_packet_assembler_core import dcpa_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_entry_byte,
   input  wire logic [2:0] req_mode,
   input  wire logic [7:0] req_wait_ms,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [5:0]      rsp_data_type,
   output logic [5:0]      rsp_payload_length,
   output logic [7:0]      rsp_packet_wait,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_is_last,
   output logic            rsp_overflowed
);

   push_type          push;
   wr_type            wr;
   rd_type            rd;
   desc_type          head;
   logic [QCNT_W-1:0] q_count;
   logic              pop;

   // front: classify entries, write payload bytes, post packet descriptors
   dcpa_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_entry_byte (req_entry_byte),
      .req_mode       (req_mode),
      .req_wait_ms    (req_wait_ms),
      .q_count        (q_count),
      .push           (push),
      .wr             (wr)
   );

   // descriptor queue decouples front and back
   dcpa_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop     (pop),
      .head    (head),
      .q_count (q_count)
   );

   // payload bytes, two banks of BUFFER_DEPTH; read data is the result byte
   dcpa_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (rd.en),
      .rd_addr (rd.addr),
      .rd_data (rsp_payload_byte)
   );

   // back: drain head packet into the result register
   dcpa_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .q_count            (q_count),
      .pop                (pop),
      .rd                 (rd),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_data_type      (rsp_data_type),
      .rsp_payload_length (rsp_payload_length),
      .rsp_packet_wait    (rsp_packet_wait),
      .rsp_is_last        (rsp_is_last),
      .rsp_overflowed     (rsp_overflowed)
   );

endmodule

`default_nettype wire

@@ rtl/core/dcpa_ram.sv @@
// ----------------------------------------------------------------------------
// dcpa_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dcpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/dcpa_front.sv @@
// ----------------------------------------------------------------------------
// dcpa_front
// Classifies table entries, fills the open packet bank, posts descriptors.
// ----------------------------------------------------------------------------
`default_nettype none

module dcpa_front import dcpa_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_entry_byte,
   input  wire logic [2:0]        req_mode,
   input  wire logic [7:0]        req_wait_ms,
   input  wire logic [QCNT_W-1:0] q_count,
   output push_type               push,
   output wr_type                 wr
);

   kind_type         kind_ff,  kind_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       wait_ff,  wait_in;
   logic             ovf_ff,   ovf_in;
   logic             bank_ff,  bank_in;

   logic flush;
   logic is_cmd;
   logic accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= KIND_NONE;
         count_ff <= '0;
         wait_ff  <= '0;
         ovf_ff   <= 1'b0;
         bank_ff  <= 1'b0;
      end else begin
         kind_ff  <= kind_in;
         count_ff <= count_in;
         wait_ff  <= wait_in;
         ovf_ff   <= ovf_in;
         bank_ff  <= bank_in;
      end
   end

   always_comb begin
      flush  = (kind_ff != KIND_NONE) && (req_mode != MODE_PARAM);
      is_cmd = (req_mode == MODE_DCS) || (req_mode == MODE_GEN);

      // a flush needs a queue slot; opening needs a bank no packet still holds
      if (flush && is_cmd)     req_ready = (q_count == QUEUE_EMPTY);
      else if (flush || is_cmd) req_ready = (q_count != QUEUE_FULL);
      else                     req_ready = 1'b1;

      accept = req_valid && req_ready;

      push.en             = 1'b0;
      push.desc.data_type = pick_type(kind_ff, count_ff);
      push.desc.len       = count_ff;
      push.desc.wait_ms   = wait_ff;
      push.desc.ovf       = ovf_ff;
      push.desc.bank      = bank_ff;

      wr.en   = 1'b0;
      wr.addr = {bank_ff, count_ff[IDX_W-1:0]};
      wr.data = req_entry_byte;

      kind_in  = kind_ff;
      count_in = count_ff;
      wait_in  = wait_ff;
      ovf_in   = ovf_ff;
      bank_in  = bank_ff;

      if (accept) begin
         if (flush) begin
            push.en  = 1'b1;
            bank_in  = ~bank_ff;
            count_in = '0;
            ovf_in   = 1'b0;
            kind_in  = KIND_NONE;
         end
         unique case (req_mode) inside
            MODE_DCS, MODE_GEN: begin
               kind_in  = (req_mode == MODE_DCS) ? KIND_DCS : KIND_GEN;
               wait_in  = req_wait_ms;
               wr.en    = 1'b1;
               wr.addr  = {bank_in, {IDX_W{1'b0}}};
               count_in = CNT_W'(1);
            end
            MODE_PARAM: begin
               if (kind_ff != KIND_NONE) begin
                  if (count_ff < CNT_W'(BUFFER_DEPTH)) begin
                     wr.en    = 1'b1;
                     count_in = CNT_W'(count_ff + CNT_W'(1));
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
            end
            MODE_END: begin
               count_in = '0;
               kind_in  = KIND_NONE;
               ovf_in   = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/dcpa_queue.sv @@
// ----------------------------------------------------------------------------
// dcpa_queue
// Two entry descriptor queue; the head entry is the packet being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module dcpa_queue import dcpa_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire push_type          push,
   input  wire logic              pop,
   output desc_type               head,
   output logic [QCNT_W-1:0]      q_count
);

   desc_type          slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff,  count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= QUEUE_EMPTY;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.en) begin
         slot_ff[wr_ptr_ff] <= push.desc;
      end
   end

   always_comb begin
      wr_ptr_in = push.en ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push.en && !pop)      count_in = QCNT_W'(count_ff + QCNT_W'(1));
      else if (pop && !push.en) count_in = QCNT_W'(count_ff - QCNT_W'(1));
   end

   assign head    = slot_ff[rd_ptr_ff];
   assign q_count = count_ff;

endmodule

`default_nettype wire

@@ rtl/core/dcpa_back.sv @@
// ----------------------------------------------------------------------------
// dcpa_back
// Drains head packet bytes into the result register, one per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dcpa_back import dcpa_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire desc_type          head,
   input  wire logic [QCNT_W-1:0] q_count,
   output logic                   pop,
   output rd_type                 rd,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [5:0]             rsp_data_type,
   output logic [5:0]             rsp_payload_length,
   output logic [7:0]             rsp_packet_wait,
   output logic                   rsp_is_last,
   output logic                   rsp_overflowed
);

   logic [IDX_W-1:0] idx_ff,   idx_in;
   logic             valid_ff, valid_in;
   logic [5:0]       dt_ff;
   logic [5:0]       len_ff;
   logic [7:0]       wait_ff;
   logic             last_ff;
   logic             ovf_ff;

   logic issue;
   logic last;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // header fields ride along with the RAM read
   always_ff @(posedge clock) begin
      if (issue) begin
         dt_ff   <= head.data_type;
         len_ff  <= 6'(head.len);
         wait_ff <= head.wait_ms;
         last_ff <= last;
         ovf_ff  <= head.ovf;
      end
   end

   always_comb begin
      issue    = (q_count != QUEUE_EMPTY) && (!valid_ff || rsp_ready);
      last     = (CNT_W'(idx_ff) + CNT_W'(1)) == head.len;
      rd.en    = issue;
      rd.addr  = {head.bank, idx_ff};
      pop      = issue && last;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (issue) begin
         valid_in = 1'b1;
         idx_in   = last ? '0 : IDX_W'(idx_ff + IDX_W'(1));
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_data_type      = dt_ff;
   assign rsp_payload_length = len_ff;
   assign rsp_packet_wait    = wait_ff;
   assign rsp_is_last        = last_ff;
   assign rsp_overflowed     = ovf_ff;

endmodule

`default_nettype wire
